### hdl/vertex_transform_perspective_divide_assert.svh
// Assertion macros for the vertex transform block.
// Used by the top level; expects clk and rst in scope.
`ifndef VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_ASSERT_SVH
`define VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_ASSERT_SVH

// Consequent must hold in the same cycle.
`define VTPD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vtpd check failed");

// Consequent must hold in the next cycle.
`define VTPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vtpd check failed");

`endif

### hdl/vtpd_pkg.sv
// Shared constants and types for the vertex transform block.
// No dependencies.
package vtpd_pkg;

  localparam int DEF_COORD_WIDTH = 32;
  localparam int DEF_FRAC_BITS   = 16;
  localparam int IO_WIDTH        = 32;
  localparam int CFG_WIDTH       = 64;
  localparam int CFG_IDX_WIDTH   = 3;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_ROW0_COLS01 = 3'd0,
    REG_ROW0_COLS23 = 3'd1,
    REG_ROW1_COLS01 = 3'd2,
    REG_ROW1_COLS23 = 3'd3,
    REG_ROW2_COLS01 = 3'd4,
    REG_ROW2_COLS23 = 3'd5,
    REG_ROW3_COLS01 = 3'd6,
    REG_ROW3_COLS23 = 3'd7
  } cfg_idx_t;

endpackage

### hdl/vtpd_col.sv
// One matrix column: three products, floor to F fraction bits, sum with translation.
// Two register stages. Depends on vtpd_pkg.
module vtpd_col
  import vtpd_pkg::*;
#(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int FRAC_BITS   = DEF_FRAC_BITS,
  localparam int AW = 2*COORD_WIDTH - FRAC_BITS + 2
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [COORD_WIDTH-1:0] pt_x,
  input  logic signed [COORD_WIDTH-1:0] pt_y,
  input  logic signed [COORD_WIDTH-1:0] pt_z,
  input  logic signed [COORD_WIDTH-1:0] m0,
  input  logic signed [COORD_WIDTH-1:0] m1,
  input  logic signed [COORD_WIDTH-1:0] m2,
  input  logic signed [COORD_WIDTH-1:0] m3,
  output logic signed [AW-1:0]          acc
);

  localparam int PW = 2*COORD_WIDTH;
  localparam int FW = PW - FRAC_BITS;

  logic signed [PW-1:0]          p0, p1, p2;
  logic signed [COORD_WIDTH-1:0] m3d;
  logic signed [FW-1:0]          f0, f1, f2;

  always_ff @(posedge clk) begin
    if (en) begin
      p0  <= pt_x * m0;
      p1  <= pt_y * m1;
      p2  <= pt_z * m2;
      m3d <= m3;
    end
  end

  // Dropping the low bits of a two's complement product floors it.
  assign f0 = p0[PW-1:FRAC_BITS];
  assign f1 = p1[PW-1:FRAC_BITS];
  assign f2 = p2[PW-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      acc <= AW'(f0) + AW'(f1) + AW'(f2) + AW'(m3d);
    end
  end

endmodule

### hdl/vtpd_div.sv
// One output lane: magnitude prep, restoring divide one quotient bit per stage,
// then sign and saturation. COORD_WIDTH+2 register stages. Depends on vtpd_pkg.
module vtpd_div
  import vtpd_pkg::*;
#(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int FRAC_BITS   = DEF_FRAC_BITS,
  localparam int AW = 2*COORD_WIDTH - FRAC_BITS + 2
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [AW-1:0]   v,
  input  logic signed [AW-1:0]   w,
  output logic [COORD_WIDTH-1:0] res,
  output logic                   sat,
  output logic                   wz
);

  localparam int C  = COORD_WIDTH;
  localparam int MW = AW + C + FRAC_BITS;

  localparam logic signed [AW-1:0] HI = {{(AW-C+1){1'b0}}, {(C-1){1'b1}}};
  localparam logic signed [AW-1:0] LO = {{(AW-C+1){1'b1}}, {(C-1){1'b0}}};

  logic [AW:0]   rem  [0:C];
  logic [C-1:0]  nl   [0:C];
  logic [C-1:0]  q    [0:C];
  logic [AW-1:0] d    [0:C];
  logic          neg  [0:C];
  logic          ovf  [0:C];
  logic          wzs  [0:C];
  logic [C-1:0]  sv   [0:C];
  logic          svs  [0:C];

  logic [AW-1:0] un, ud;
  logic [MW-1:0] num_ext, den_ext, num_hi;
  logic [C-1:0]  sv_next;
  logic          svs_next;

  always_comb begin
    un       = v[AW-1] ? AW'(-v) : AW'(v);
    ud       = w[AW-1] ? AW'(-w) : AW'(w);
    num_ext  = {{C{1'b0}}, un, {FRAC_BITS{1'b0}}};
    den_ext  = {{FRAC_BITS{1'b0}}, ud, {C{1'b0}}};
    num_hi   = num_ext >> C;
    svs_next = (v > HI) || (v < LO);
    if (v > HI) begin
      sv_next = HI[C-1:0];
    end else if (v < LO) begin
      sv_next = LO[C-1:0];
    end else begin
      sv_next = v[C-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num_hi[AW:0];
      nl[0]  <= num_ext[C-1:0];
      q[0]   <= '0;
      d[0]   <= ud;
      neg[0] <= v[AW-1] ^ w[AW-1];
      ovf[0] <= num_ext >= den_ext;
      wzs[0] <= (w == '0);
      sv[0]  <= sv_next;
      svs[0] <= svs_next;
    end
  end

  for (genvar k = 0; k < C; k++) begin : g_step
    logic [AW:0] trial;
    logic        take;

    assign trial = {rem[k][AW-1:0], nl[k][C-1]};
    assign take  = trial >= {1'b0, d[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= take ? (trial - {1'b0, d[k]}) : trial;
        nl[k+1]  <= {nl[k][C-2:0], 1'b0};
        q[k+1]   <= {q[k][C-2:0], take};
        d[k+1]   <= d[k];
        neg[k+1] <= neg[k];
        ovf[k+1] <= ovf[k];
        wzs[k+1] <= wzs[k];
        sv[k+1]  <= sv[k];
        svs[k+1] <= svs[k];
      end
    end
  end

  logic         clip;
  logic [C-1:0] qf;

  always_comb begin
    qf   = q[C];
    clip = ovf[C] || (neg[C] ? (qf[C-1] && (|qf[C-2:0])) : qf[C-1]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wz <= wzs[C];
      if (wzs[C]) begin
        res <= sv[C];
        sat <= svs[C];
      end else if (clip) begin
        res <= neg[C] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
        sat <= 1'b1;
      end else begin
        res <= neg[C] ? -qf : qf;
        sat <= 1'b0;
      end
    end
  end

endmodule

### hdl/vertex_transform_perspective_divide.sv
// A request passes the column product and sum registers, then the divide prep, step and output registers.
// Throughput: one point per cycle; the whole pipeline advances together and
// holds when the output register is full and not taken.
// The divide takes one quotient bit per stage, which sets the latency.
// Reset (rst, synchronous) clears all valid bits and loads the identity matrix.
`include "vertex_transform_perspective_divide_assert.svh"

module vertex_transform_perspective_divide
  import vtpd_pkg::*;
#(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0]   cfg_index,
  input  logic [CFG_WIDTH-1:0]       cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [IO_WIDTH-1:0] in_x,
  input  logic signed [IO_WIDTH-1:0] in_y,
  input  logic signed [IO_WIDTH-1:0] in_z,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [IO_WIDTH-1:0] out_x,
  output logic signed [IO_WIDTH-1:0] out_y,
  output logic signed [IO_WIDTH-1:0] out_z,
  output logic                       w_was_zero,
  output logic                       saturated
);

  localparam int C   = COORD_WIDTH;
  localparam int AW  = 2*C - FRAC_BITS + 2;
  localparam int LAT = C + 4;
  localparam logic [CFG_WIDTH-1:0] ONE_LO = CFG_WIDTH'(1) << FRAC_BITS;
  localparam logic [CFG_WIDTH-1:0] ONE_HI = ONE_LO << 32;

  logic [CFG_WIDTH-1:0] mreg [0:7];
  logic [LAT-1:0]       vld;
  logic                 en;

  always_ff @(posedge clk) begin
    if (rst) begin
      mreg[REG_ROW0_COLS01] <= ONE_LO;
      mreg[REG_ROW0_COLS23] <= '0;
      mreg[REG_ROW1_COLS01] <= ONE_HI;
      mreg[REG_ROW1_COLS23] <= '0;
      mreg[REG_ROW2_COLS01] <= '0;
      mreg[REG_ROW2_COLS23] <= ONE_LO;
      mreg[REG_ROW3_COLS01] <= '0;
      mreg[REG_ROW3_COLS23] <= ONE_HI;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_ROW0_COLS01: mreg[REG_ROW0_COLS01] <= cfg_data;
        REG_ROW0_COLS23: mreg[REG_ROW0_COLS23] <= cfg_data;
        REG_ROW1_COLS01: mreg[REG_ROW1_COLS01] <= cfg_data;
        REG_ROW1_COLS23: mreg[REG_ROW1_COLS23] <= cfg_data;
        REG_ROW2_COLS01: mreg[REG_ROW2_COLS01] <= cfg_data;
        REG_ROW2_COLS23: mreg[REG_ROW2_COLS23] <= cfg_data;
        REG_ROW3_COLS01: mreg[REG_ROW3_COLS01] <= cfg_data;
        REG_ROW3_COLS23: mreg[REG_ROW3_COLS23] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance everything unless a finished result is waiting and not taken.
  assign en        = !vld[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  logic signed [AW-1:0] col_acc [0:3];

  for (genvar c = 0; c < 4; c++) begin : g_col
    vtpd_col #(.COORD_WIDTH(C), .FRAC_BITS(FRAC_BITS)) u_col (
      .clk  (clk),
      .en   (en),
      .pt_x (in_x[C-1:0]),
      .pt_y (in_y[C-1:0]),
      .pt_z (in_z[C-1:0]),
      .m0   (mreg[c/2][32*(c%2) +: C]),
      .m1   (mreg[2 + c/2][32*(c%2) +: C]),
      .m2   (mreg[4 + c/2][32*(c%2) +: C]),
      .m3   (mreg[6 + c/2][32*(c%2) +: C]),
      .acc  (col_acc[c])
    );
  end

  logic [C-1:0] lane_res [0:2];
  logic         lane_sat [0:2];
  logic         lane_wz  [0:2];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    vtpd_div #(.COORD_WIDTH(C), .FRAC_BITS(FRAC_BITS)) u_div (
      .clk (clk),
      .en  (en),
      .v   (col_acc[i]),
      .w   (col_acc[3]),
      .res (lane_res[i]),
      .sat (lane_sat[i]),
      .wz  (lane_wz[i])
    );
  end

  assign out_x      = IO_WIDTH'($signed(lane_res[0]));
  assign out_y      = IO_WIDTH'($signed(lane_res[1]));
  assign out_z      = IO_WIDTH'($signed(lane_res[2]));
  assign w_was_zero = lane_wz[0];
  assign saturated  = lane_sat[0] | lane_sat[1] | lane_sat[2];

  `VTPD_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, vld[0])
  `VTPD_ASSERT_NEXT(a_stall_holds_valid, !in_ready, $stable(vld))
  `VTPD_ASSERT_NOW(a_lanes_agree_wz, out_valid,
    (lane_wz[0] == lane_wz[1]) && (lane_wz[1] == lane_wz[2]))

endmodule

### tb/sv/tb_top.sv
// Testbench for the homogeneous 4x4 vertex transform with perspective divide.
// Predicts each point in Q16.16 with a scoreboard class; depends on vtpd_pkg.
module tb_top;
  import vtpd_pkg::*;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int LAT = CW + 4;

  typedef struct packed {
    logic [31:0] x, y, z;
    logic        wz, sat;
  } vertex_res_t;

  class vertex_scoreboard;
    logic [63:0] mat_regs [8];
    vertex_res_t pending [$];
    int mismatches = 0;
    int checked = 0;
    int wzero_seen = 0;
    int sat_seen = 0;

    function void reset_matrix();
      mat_regs[0] = 64'd65536;
      mat_regs[1] = 64'd0;
      mat_regs[2] = 64'd281474976710656;
      mat_regs[3] = 64'd0;
      mat_regs[4] = 64'd0;
      mat_regs[5] = 64'd65536;
      mat_regs[6] = 64'd0;
      mat_regs[7] = 64'd281474976710656;
    endfunction

    function longint coef(int r, int c);
      logic [63:0] word;
      word = mat_regs[r*2 + c/2];
      return longint'($signed(word[32*(c%2) +: 32]));
    endfunction

    // Floor of a full product after dropping the fraction bits.
    function longint column_sum(int c, longint pt[3]);
      longint acc;
      logic signed [127:0] p;
      acc = coef(3, c);
      for (int r = 0; r < 3; r++) begin
        p = 128'(pt[r]) * 128'(coef(r, c));
        p = p >>> FB;
        acc += longint'(p);
      end
      return acc;
    endfunction

    function longint clip(longint v, ref bit sat);
      longint hi, lo;
      hi = (longint'(1) <<< (CW-1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin sat = 1; return hi; end
      if (v < lo) begin sat = 1; return lo; end
      return v;
    endfunction

    function longint div_round_zero(longint num, longint den, ref bit sat);
      bit neg;
      logic [127:0] un, ud, q, lim;
      neg = (num < 0) != (den < 0);
      un = num < 0 ? 128'(-num) : 128'(num);
      ud = den < 0 ? 128'(-den) : 128'(den);
      lim = neg ? (128'd1 << (CW-1)) : (128'd1 << (CW-1)) - 1;
      q = (un << FB) / ud;
      if (q > lim) begin q = lim; sat = 1; end
      return neg ? -longint'(q) : longint'(q);
    endfunction

    function void note_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      longint pt[3], v[3], w, r;
      bit sat;
      vertex_res_t e;
      sat = 0;
      pt[0] = longint'($signed(x));
      pt[1] = longint'($signed(y));
      pt[2] = longint'($signed(z));
      for (int i = 0; i < 3; i++) v[i] = column_sum(i, pt);
      w = column_sum(3, pt);
      for (int i = 0; i < 3; i++) begin
        r = (w == 0) ? clip(v[i], sat) : div_round_zero(v[i], w, sat);
        v[i] = r;
      end
      e.x = v[0][31:0];
      e.y = v[1][31:0];
      e.z = v[2][31:0];
      e.wz = (w == 0);
      e.sat = sat;
      pending.push_back(e);
    endfunction

    function void check_result(vertex_res_t a);
      vertex_res_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", a);
        return;
      end
      e = pending.pop_front();
      if (e.wz) wzero_seen++;
      if (e.sat) sat_seen++;
      if (a !== e) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: x %h/%h y %h/%h z %h/%h wz %b/%b sat %b/%b (exp/act)",
                   e.x, a.x, e.y, a.y, e.z, a.z, e.wz, a.wz, e.sat, a.sat);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0] cfg_data = '0;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic signed [31:0] in_x = 0, in_y = 0, in_z = 0;
  logic signed [31:0] out_x, out_y, out_z;
  logic w_was_zero, saturated;
  vertex_scoreboard sb;
  int sent = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  vertex_transform_perspective_divide DUT (.*);

  // Receiver: stall pattern with calm stretches; check on the rising edge.
  initial begin
    int mode;
    mode = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        sb.check_result({out_x, out_y, out_z, w_was_zero, saturated});
      @(negedge clk);
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_ready <= 1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 15) != 0);
      endcase
    end
  end

  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic write_reg(cfg_idx_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.mat_regs[idx] = val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // Hold the request until accepted; caller is at the falling edge.
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_valid <= 1;
    in_x <= x;
    in_y <= y;
    in_z <= z;
    do @(posedge clk); while (!in_ready);
    sb.note_point(x, y, z);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LAT + 4) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom();
      3: return 32'($signed($urandom_range(0, 20 * 65536)) - 10 * 65536);
      default: return 32'($signed($urandom_range(0, 2 * 65536)) - 65536);
    endcase
  endfunction

  task automatic random_burst(int n, bit wide);
    int burst;
    int gap;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 5);
        // Drop valid only when a real gap follows.
        if (gap > 0) begin
          in_valid <= 0;
          repeat (gap) @(negedge clk);
        end
        burst = $urandom_range(1, 20);
      end
      burst--;
      if (wide) send_point($urandom(), $urandom(), $urandom());
      else send_point(rand_coord(), rand_coord(), rand_coord());
    end
    in_valid <= 0;
  endtask

  task automatic load_matrix(int kind);
    for (int i = 0; i < 8; i++) begin
      logic [63:0] v;
      case (kind)
        0: v = {$urandom(), $urandom()};
        1: v = {32'($signed($urandom_range(0, 4 * 65536)) - 2 * 65536),
                32'($signed($urandom_range(0, 4 * 65536)) - 2 * 65536)};
        2: v = {32'h7fff_ffff, 32'h8000_0000};
        default: v = '0;
      endcase
      write_reg(cfg_idx_t'(i), v);
    end
  endtask

  initial begin
    logic [31:0] ext [4];
    sb = new();
    sb.reset_matrix();
    ext = '{32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // Identity matrix: extremes pass through.
    for (int i = 0; i < 4; i++) send_point(ext[i], ext[3 - i], ext[(i + 1) % 4]);
    in_valid <= 0;
    drain();
    // Zero w column: outputs come back undivided.
    write_reg(REG_ROW3_COLS23, 64'd0);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    in_valid <= 0;
    drain();
    // Tiny negative w after flooring; divide by -1 ulp.
    write_reg(REG_ROW0_COLS23, {32'hffff_ffff, 32'h0});
    send_point(32'h0000_0001, 32'h0000_0100, 32'h0);
    send_point(32'h0001_0000, 32'h0, 32'h0);
    send_point(32'h8000_0000, 32'h0, 32'h0);
    in_valid <= 0;
    drain();
    // Perspective: w = z.
    write_reg(REG_ROW2_COLS23, {32'h0001_0000, 32'h0001_0000});
    write_reg(REG_ROW3_COLS23, 64'd0);
    write_reg(REG_ROW0_COLS23, 64'd0);
    send_point(32'h0004_0000, 32'hfffc_0000, 32'h0002_0000);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
    send_point(32'h0001_0000, 32'h0001_0000, 32'hffff_0000);
    send_point(32'h1234_5678, 32'h0, 32'h0);
    in_valid <= 0;
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      load_matrix(ph == 7 ? 2 : (ph == 6 ? 3 : ph % 2));
      random_burst(ph == 7 || ph == 6 ? 60 : 150, ph % 3 == 2);
      drain();
    end
    $display("sent %0d points, checked %0d results", sent, sb.checked);
    $display("zero-w results %0d, saturated results %0d", sb.wzero_seen, sb.sat_seen);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
